[sv/touch_tap_classifier_defines.svh]
// ----------------------------------------------------------------------------
// Touch tap classifier - assertion macros
// Shared concurrent assertion forms, sampled on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef TOUCH_TAP_CLASSIFIER_DEFINES_SVH
`define TOUCH_TAP_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define TTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ttc_pkg.sv]
// ----------------------------------------------------------------------------
// Touch tap classifier package
// Item types, register indexes, phase and gesture codes, mirror function.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // Touch phase codes
  localparam logic [1:0] PH_NONE    = 2'd0;
  localparam logic [1:0] PH_START   = 2'd1;
  localparam logic [1:0] PH_RUNNING = 2'd2;
  localparam logic [1:0] PH_ENDED   = 2'd3;

  // Gesture codes
  localparam logic [1:0] G_NONE = 2'd0;
  localparam logic [1:0] G_TAP  = 2'd1;
  localparam logic [1:0] G_LONG = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_LIMIT = 3'd6;

  typedef struct packed {
    logic               touched;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [TICK_W-1:0]  now_tick;
  } in_item_t;

  typedef struct packed {
    logic               event_valid;
    logic [1:0]         touch_state;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [1:0]         gesture;
  } out_item_t;

  typedef struct packed {
    logic               invert_x;
    logic               invert_y;
    logic [COORD_W-1:0] screen_width;
    logic [COORD_W-1:0] screen_height;
    logic [TICK_W-1:0]  tap_limit;
    logic [TICK_W-1:0]  long_limit;
    logic [TICK_W-1:0]  invalid_limit;
  } cfg_t;

  // Absolute distance from the screen edge when enabled.
  function automatic logic [COORD_W-1:0] mirror(input logic               enable,
                                                input logic [COORD_W-1:0] size,
                                                input logic [COORD_W-1:0] coord);
    logic [COORD_W-1:0] res;
    if (!enable) begin
      res = coord;
    end else if (size >= coord) begin
      res = size - coord;
    end else begin
      res = coord - size;
    end
    return res;
  endfunction

endpackage

[sv/ttc_in_if.sv]
// ----------------------------------------------------------------------------
// Touch poll channel
// Valid/ready channel carrying one panel poll per transfer.
// ----------------------------------------------------------------------------
interface ttc_in_if;
  logic              valid;
  logic              ready;
  ttc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/ttc_out_if.sv]
// ----------------------------------------------------------------------------
// Touch result channel
// Valid/ready channel carrying one classified result per transfer.
// ----------------------------------------------------------------------------
interface ttc_out_if;
  logic               valid;
  logic               ready;
  ttc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/ttc_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ttc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ttc_pkg::CFG_IDX_W-1:0]      index;
  logic [ttc_pkg::CFG_DAT_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/ttc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Touch tap classifier configuration registers
// Holds the mirroring and timing registers; writes to unknown indexes drop.
// ----------------------------------------------------------------------------
module ttc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  ttc_cfg_if.sink       cfg_ch,
  output ttc_pkg::cfg_t cfg
);

  ttc_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_x      <= 1'b0;
      cfg_r.invert_y      <= 1'b0;
      cfg_r.screen_width  <= 12'd320;
      cfg_r.screen_height <= 12'd240;
      cfg_r.tap_limit     <= 32'd300;
      cfg_r.long_limit    <= 32'd800;
      cfg_r.invalid_limit <= 32'd5000;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ttc_pkg::REG_INVERT_X:      cfg_r.invert_x      <= cfg_ch.data[0];
        ttc_pkg::REG_INVERT_Y:      cfg_r.invert_y      <= cfg_ch.data[0];
        ttc_pkg::REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_ch.data[ttc_pkg::COORD_W-1:0];
        ttc_pkg::REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_ch.data[ttc_pkg::COORD_W-1:0];
        ttc_pkg::REG_TAP_LIMIT:     cfg_r.tap_limit     <= cfg_ch.data[ttc_pkg::TICK_W-1:0];
        ttc_pkg::REG_LONG_LIMIT:    cfg_r.long_limit    <= cfg_ch.data[ttc_pkg::TICK_W-1:0];
        ttc_pkg::REG_INVALID_LIMIT: cfg_r.invalid_limit <= cfg_ch.data[ttc_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/touch_tap_classifier.sv]
// ----------------------------------------------------------------------------
// Touch tap classifier
// Tracks a press through none/start/running/ended and reports tap or long
// press from the press duration, one result per panel poll.
// ----------------------------------------------------------------------------
//  Channel  Dir  Transfer carries
//  in_ch    in   touched, raw_x, raw_y, now_tick
//  out_ch   out  event_valid, touch_state, pos_x, pos_y, gesture
//  cfg_ch   in   register index, 32-bit write data
//
//  One poll per cycle sustained while out_ch is ready; a poll passes the
//  input register, then classify logic into the result register.
//  Touch state updates as a poll moves into the result register.
//  A held result stalls the input register; ready passes back combinationally.
//  rst_n is synchronous: clears phase, position, start tick and valid flags.
// ----------------------------------------------------------------------------
`include "touch_tap_classifier_defines.svh"

module touch_tap_classifier (
  input  logic      clk,
  input  logic      rst_n,
  ttc_in_if.sink    in_ch,
  ttc_out_if.source out_ch,
  ttc_cfg_if.sink   cfg_ch
);

  ttc_pkg::cfg_t      cfg;

  logic               in_valid_r;
  ttc_pkg::in_item_t  in_data_r;
  logic               out_valid_r;
  ttc_pkg::out_item_t out_data_r;
  ttc_pkg::out_item_t out_data_nxt;

  logic [1:0]                  phase_r, phase_nxt;
  logic [ttc_pkg::COORD_W-1:0] last_x_r, last_x_nxt;
  logic [ttc_pkg::COORD_W-1:0] last_y_r, last_y_nxt;
  logic [ttc_pkg::TICK_W-1:0]  start_tick_r, start_tick_nxt;

  logic                        advance;
  logic                        evt;
  logic [ttc_pkg::TICK_W-1:0]  dur;
  logic [1:0]                  gest;

  ttc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Move the staged poll on when the result slot is free or being taken.
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    phase_nxt      = phase_r;
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    start_tick_nxt = start_tick_r;
    evt            = 1'b0;
    gest           = ttc_pkg::G_NONE;

    if (in_data_r.touched) begin
      case (phase_r)
        ttc_pkg::PH_NONE:  phase_nxt = ttc_pkg::PH_START;
        ttc_pkg::PH_ENDED: phase_nxt = ttc_pkg::PH_NONE;
        default:           phase_nxt = ttc_pkg::PH_RUNNING;
      endcase
      last_x_nxt = ttc_pkg::mirror(cfg.invert_x, cfg.screen_width, in_data_r.raw_x);
      last_y_nxt = ttc_pkg::mirror(cfg.invert_y, cfg.screen_height, in_data_r.raw_y);
      evt        = 1'b1;
    end else begin
      case (phase_r)
        ttc_pkg::PH_START,
        ttc_pkg::PH_RUNNING: phase_nxt = ttc_pkg::PH_ENDED;
        default:             phase_nxt = ttc_pkg::PH_NONE;
      endcase
      evt = (phase_nxt != phase_r);
    end

    if (evt && phase_nxt == ttc_pkg::PH_START) begin
      start_tick_nxt = in_data_r.now_tick;
    end

    dur = in_data_r.now_tick - start_tick_nxt;

    if (phase_nxt == ttc_pkg::PH_ENDED && dur < cfg.invalid_limit) begin
      if (dur < cfg.tap_limit) begin
        gest = ttc_pkg::G_TAP;
      end else if (dur > cfg.long_limit) begin
        gest = ttc_pkg::G_LONG;
      end
    end

    out_data_nxt = '0;
    if (evt) begin
      out_data_nxt.event_valid = 1'b1;
      out_data_nxt.touch_state = phase_nxt;
      out_data_nxt.pos_x       = last_x_nxt;
      out_data_nxt.pos_y       = last_y_nxt;
      out_data_nxt.gesture     = gest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= ttc_pkg::PH_NONE;
      last_x_r     <= '0;
      last_y_r     <= '0;
      start_tick_r <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      // Commit state only when the poll leaves the input register.
      if (advance && in_valid_r) begin
        phase_r      <= phase_nxt;
        last_x_r     <= last_x_nxt;
        last_y_r     <= last_y_nxt;
        start_tick_r <= start_tick_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      in_data_r <= in_ch.data;
    end
    if (advance && in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  `TTC_ASSERT_IMP(a_no_event_zero, out_valid_r && !out_data_r.event_valid, out_data_r == '0, "non-event result carries data")
  `TTC_ASSERT_IMP(a_gesture_on_end, out_valid_r && out_data_r.gesture != ttc_pkg::G_NONE, out_data_r.touch_state == ttc_pkg::PH_ENDED, "gesture outside ended phase")
  `TTC_ASSERT_IMP(a_state_matches, out_valid_r && out_data_r.event_valid, out_data_r.touch_state == phase_r, "reported state differs from phase")
  `TTC_ASSERT_IMP(a_stall_source, !in_ch.ready, out_valid_r && in_valid_r, "input stalled with free pipeline")

endmodule
